// ----- rtl/wrc_pkg.sv -----
// ----------------------------------------------------------------------------
// wrc_pkg: shared types and constants of the WAV RIFF chunk parser
// Beat payloads, the status codes and the job record that passes from the
// byte parser to the sequencer.
// ----------------------------------------------------------------------------
package wrc_pkg;

  localparam int unsigned PosW  = 33;
  localparam int unsigned NextW = 34;
  localparam int unsigned OffW  = 5;

  localparam logic [31:0]     TagFmt  = 32'h2074_6D66;
  localparam logic [31:0]     TagData = 32'h6174_6164;
  localparam logic [PosW-1:0] PosMax  = {PosW{1'b1}};
  localparam logic [OffW-1:0] OffSat  = 5'd16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_ZERO    = 2'd2,
    ST_TRUNC   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_PARSE,
    S_FRAMES,
    S_SECS,
    S_OUT
  } seq_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [30:0] frame_count;
    logic [30:0] duration_seconds;
    status_e     status;
  } out_t;

  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] data_size;
    status_e     status;
  } job_t;

endpackage

// ----- rtl/wrc_parser.sv -----
// ----------------------------------------------------------------------------
// wrc_parser: byte-serial RIFF chunk walker
// Tracks the file offset, the walk end and the current chunk, keeps the
// format and data fields, and hands a job record out on the final byte.
// ----------------------------------------------------------------------------
module wrc_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  wrc_pkg::in_t  in_i,
  output logic          job_valid_o,
  output wrc_pkg::job_t job_o
);
  import wrc_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  walk_end_q, walk_end_d;
  logic [NextW-1:0] next_q, next_d;
  logic [PosW-1:0]  start_q, start_d;
  logic             entered_q, entered_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [31:0]      tag_q, tag_d;
  logic [31:0]      len_q, len_d;
  logic [15:0]      chan_q, chan_d;
  logic [31:0]      rate_q, rate_d;
  logic [31:0]      dsize_q, dsize_d;
  logic [1:0]       seen_q, seen_d;

  logic [7:0]       b;
  logic [PosW-1:0]  we_base;
  logic             enter;
  logic             entered;
  logic [OffW-1:0]  off;
  logic [31:0]      tag_cur;
  logic [31:0]      len_cur;
  logic [32:0]      padded;
  logic             fmt_ok;
  logic             trunc;

  always_comb begin
    b       = in_i.data_byte;
    pos_d   = pos_q;
    walk_end_d = walk_end_q;
    next_d  = next_q;
    start_d = start_q;
    tag_d   = tag_q;
    len_d   = len_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    dsize_d = dsize_q;
    seen_d  = seen_q;
    padded  = '0;
    we_base = (pos_q[1:0] == 2'd0) ? PosW'(8) : walk_end_q;

    if (pos_q[PosW-1:3] == '0 && pos_q[2]) begin
      walk_end_d = we_base + (PosW'(b) << {pos_q[1:0], 3'b000});
    end

    enter = (pos_q >= PosW'(12)) && ({1'b0, pos_q} == next_q) &&
            (next_q < {1'b0, walk_end_q});
    entered = entered_q || enter;
    off     = enter ? '0 : off_q;
    tag_cur = enter ? '0 : tag_q;
    len_cur = enter ? '0 : len_q;
    fmt_ok  = (tag_q == TagFmt) && (len_q >= 32'd8);

    if (enter) begin
      start_d = pos_q;
    end

    if (entered) begin
      if (off < OffW'(4)) begin
        tag_d = {b, tag_cur[31:8]};
        len_d = len_cur;
      end else if (off < OffW'(8)) begin
        len_d = {b, len_cur[31:8]};
        if (off == OffW'(7)) begin
          padded = {1'b0, len_d[31:1], 1'b0} + {31'b0, len_d[0], 1'b0};
          next_d = {1'b0, start_q} + NextW'(8) + NextW'(padded);
          if (tag_q == TagData) begin
            dsize_d   = len_d;
            seen_d[1] = 1'b1;
          end
        end
      end else if (fmt_ok && off >= OffW'(10) && off < OffW'(16)) begin
        if (off == OffW'(10)) begin
          chan_d[7:0] = b;
        end else if (off == OffW'(11)) begin
          chan_d[15:8] = b;
        end else begin
          unique case (off[1:0])
            2'd0:    rate_d[7:0]   = b;
            2'd1:    rate_d[15:8]  = b;
            2'd2:    rate_d[23:16] = b;
            default: rate_d[31:24] = b;
          endcase
          if (off == OffW'(15)) begin
            seen_d[0] = 1'b1;
          end
        end
      end
    end

    entered_d = entered;
    off_d     = (!entered || off == OffSat) ? off : off + OffW'(1);
    if (pos_q != PosMax) begin
      pos_d = pos_q + PosW'(1);
    end

    trunc = (pos_q < PosW'(11)) ||
            (entered && (off < OffW'(7) || (fmt_ok && off < OffW'(15))));
  end

  always_comb begin
    job_valid_o       = beat_i && in_i.end_of_file;
    job_o.channels    = chan_d;
    job_o.sample_rate = rate_d;
    job_o.data_size   = dsize_d;
    if (trunc) begin
      job_o.status = ST_TRUNC;
    end else if (seen_d != 2'b11) begin
      job_o.status = ST_MISSING;
    end else if (chan_d == '0 || rate_d == '0) begin
      job_o.status = ST_ZERO;
    end else begin
      job_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      walk_end_q <= '0;
      next_q     <= NextW'(12);
      start_q    <= '0;
      entered_q  <= 1'b0;
      off_q      <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      chan_q     <= '0;
      rate_q     <= '0;
      dsize_q    <= '0;
      seen_q     <= '0;
    end else if (beat_i) begin
      if (in_i.end_of_file) begin
        pos_q      <= '0;
        walk_end_q <= '0;
        next_q     <= NextW'(12);
        start_q    <= '0;
        entered_q  <= 1'b0;
        off_q      <= '0;
        tag_q      <= '0;
        len_q      <= '0;
        chan_q     <= '0;
        rate_q     <= '0;
        dsize_q    <= '0;
        seen_q     <= '0;
      end else begin
        pos_q      <= pos_d;
        walk_end_q <= walk_end_d;
        next_q     <= next_d;
        start_q    <= start_d;
        entered_q  <= entered_d;
        off_q      <= off_d;
        tag_q      <= tag_d;
        len_q      <= len_d;
        chan_q     <= chan_d;
        rate_q     <= rate_d;
        dsize_q    <= dsize_d;
        seen_q     <= seen_d;
      end
    end
  end

endmodule

// ----- rtl/wrc_divider.sv -----
// ----------------------------------------------------------------------------
// wrc_divider: shared restoring divider
// Divides a 32-bit dividend by a 33-bit divisor, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient; the caller masks that case.
// ----------------------------------------------------------------------------
module wrc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  import wrc_pkg::*;

  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] dvs_q;
  logic [4:0]  cnt_q;
  logic        active_q;
  logic        done_q;
  logic [33:0] trial;
  logic [33:0] diff;

  always_comb begin
    trial = {rem_q, quo_q[31]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[32:0];
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = trial[32:0];
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q    <= '0;
        active_q <= 1'b1;
      end else if (active_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/wav_riff_chunk_parser.sv -----
// ----------------------------------------------------------------------------
// wav_riff_chunk_parser: WAV header parser with frame count and duration
// Walks the RIFF chunks of a byte stream and reports the format fields, the
// frame count and the duration of each file.
// ----------------------------------------------------------------------------
// Every byte but the last of a file is accepted without a stall, so a header
// streams in at one beat per clock. The final byte starts two passes through
// the shared one-bit-per-cycle divider (frames, then seconds), and the input
// stays stalled through both, longer while an earlier result still waits, until
// the result moves into the output register. The next file may then start
// while that result waits.
module wav_riff_chunk_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wrc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wrc_pkg::out_t out_data_o
);
  import wrc_pkg::*;

  seq_state_e  state_q, state_d;
  logic        beat;
  logic        job_valid;
  job_t        job;
  job_t        job_q;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [32:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quotient;
  logic [30:0] frames_q;
  logic [30:0] secs_q;
  logic [30:0] frames_now;
  logic [30:0] secs_now;
  logic        out_valid_q;
  out_t        out_q;
  logic        out_free;
  logic        load_out;

  assign beat     = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  wrc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .in_i        (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  wrc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign frames_now = (job_q.channels == '0) ? '0 : div_quotient[30:0];
  assign secs_now   = (job_q.sample_rate == '0) ? '0 : div_quotient[30:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_PARSE:  if (job_valid) state_d = S_FRAMES;
      S_FRAMES: if (div_done) state_d = S_SECS;
      S_SECS:   if (div_done) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_PARSE;
      default:  state_d = S_PARSE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    div_dividend = job.data_size;
    div_divisor  = {16'b0, job.channels, 1'b0};
    load_out     = 1'b0;
    unique case (state_q)
      S_PARSE: begin
        in_ready_o = 1'b1;
        div_start  = job_valid;
      end
      S_FRAMES: begin
        div_start    = div_done;
        div_dividend = {1'b0, frames_now};
        div_divisor  = {1'b0, job_q.sample_rate};
      end
      S_SECS: begin
      end
      S_OUT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PARSE && job_valid) begin
      job_q <= job;
    end
    if (state_q == S_FRAMES && div_done) begin
      frames_q <= frames_now;
    end
    if (state_q == S_SECS && div_done) begin
      secs_q <= secs_now;
    end
    if (load_out) begin
      out_q.channels         <= job_q.channels;
      out_q.sample_rate      <= job_q.sample_rate;
      out_q.frame_count      <= frames_q;
      out_q.duration_seconds <= secs_q;
      out_q.status           <= job_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
